FILE: design/vegd_pkg.sv
// Shared types, constants and helpers for the Gaussian-damped velocity estimator.
// No dependencies; used by vegd_ctrl, vegd_dp and the top level.
package vegd_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // 9.80665 * 2^24, counts-to-m/s^2 scale (1/16384 folded into the shift)
    localparam logic [27:0] ACC_SCALE = 28'd164528285;
    // log2(e) in Q.16
    localparam logic [16:0] LOG2E = 17'd94548;
    localparam logic signed [65:0] OUT_MAX = 66'sd1048575;
    // quotient of |v|^2/(2 sigma^2) stays below 2^20 once the gain is nonzero
    localparam int DIV_STEPS = 20;

    // register indexes
    localparam logic [1:0] CFG_MODE       = 2'd0;
    localparam logic [1:0] CFG_SIGMA_FILM = 2'd1;
    localparam logic [1:0] CFG_SIGMA_AERO = 2'd2;

    localparam logic [15:0] SIGMA_FILM_RST = 16'd3277;
    localparam logic [15:0] SIGMA_AERO_RST = 16'd819;

    // datapath commands
    localparam logic [4:0] OP_NONE  = 5'd0;
    localparam logic [4:0] OP_LOAD  = 5'd1;
    localparam logic [4:0] OP_ACC_M = 5'd2;
    localparam logic [4:0] OP_ACC_W = 5'd3;
    localparam logic [4:0] OP_DT_M  = 5'd4;
    localparam logic [4:0] OP_DT_W  = 5'd5;
    localparam logic [4:0] OP_MEAS  = 5'd6;
    localparam logic [4:0] OP_SQ_M  = 5'd7;
    localparam logic [4:0] OP_SQ_W  = 5'd8;
    localparam logic [4:0] OP_SIG_M = 5'd9;
    localparam logic [4:0] OP_SIG_W = 5'd10;
    localparam logic [4:0] OP_CMP   = 5'd11;
    localparam logic [4:0] OP_DIV   = 5'd12;
    localparam logic [4:0] OP_LOG_M = 5'd13;
    localparam logic [4:0] OP_LOG_W = 5'd14;
    localparam logic [4:0] OP_INT_M = 5'd15;
    localparam logic [4:0] OP_INT_W = 5'd16;
    localparam logic [4:0] OP_GAIN  = 5'd17;
    localparam logic [4:0] OP_OUT_M = 5'd18;
    localparam logic [4:0] OP_OUT_W = 5'd19;
    localparam logic [4:0] OP_EMIT  = 5'd20;

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] axis;
    } cmd_t;

    typedef struct packed {
        logic gain_zero;
    } status_t;

    // 2^(-k/16) in Q.16
    function automatic logic [16:0] pow2_neg(input logic [4:0] k);
        logic [16:0] r;
        unique case (k)
            5'd0:    r = 17'd65536;
            5'd1:    r = 17'd62757;
            5'd2:    r = 17'd60097;
            5'd3:    r = 17'd57549;
            5'd4:    r = 17'd55109;
            5'd5:    r = 17'd52773;
            5'd6:    r = 17'd50535;
            5'd7:    r = 17'd48393;
            5'd8:    r = 17'd46341;
            5'd9:    r = 17'd44376;
            5'd10:   r = 17'd42495;
            5'd11:   r = 17'd40693;
            5'd12:   r = 17'd38968;
            5'd13:   r = 17'd37316;
            5'd14:   r = 17'd35734;
            5'd15:   r = 17'd34219;
            default: r = 17'd32768;
        endcase
        return r;
    endfunction

    // divide by 2^s, round to nearest, ties away from zero
    function automatic logic signed [65:0] rnd_shr(input logic signed [65:0] v, input int s);
        logic [65:0] m;
        logic [65:0] r;
        m = v[65] ? 66'(-v) : 66'(v);
        r = (m + (66'd1 << (s - 1))) >> s;
        return v[65] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -66'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

FILE: design/vegd_ctrl.sv
// Sequencer for the estimator: walks the datapath through one sample.
// Depends on vegd_pkg (command and status types, op codes).
module vegd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  vegd_pkg::status_t status,
    output vegd_pkg::cmd_t    cmd
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_ACC_M = 5'd1;
    localparam logic [4:0] ST_ACC_W = 5'd2;
    localparam logic [4:0] ST_DT_M  = 5'd3;
    localparam logic [4:0] ST_DT_W  = 5'd4;
    localparam logic [4:0] ST_MEAS  = 5'd5;
    localparam logic [4:0] ST_SQ_M  = 5'd6;
    localparam logic [4:0] ST_SQ_W  = 5'd7;
    localparam logic [4:0] ST_SIG_M = 5'd8;
    localparam logic [4:0] ST_SIG_W = 5'd9;
    localparam logic [4:0] ST_CMP   = 5'd10;
    localparam logic [4:0] ST_DIV   = 5'd11;
    localparam logic [4:0] ST_LOG_M = 5'd12;
    localparam logic [4:0] ST_LOG_W = 5'd13;
    localparam logic [4:0] ST_INT_M = 5'd14;
    localparam logic [4:0] ST_INT_W = 5'd15;
    localparam logic [4:0] ST_GAIN  = 5'd16;
    localparam logic [4:0] ST_OUT_M = 5'd17;
    localparam logic [4:0] ST_OUT_W = 5'd18;
    localparam logic [4:0] ST_EMIT  = 5'd19;

    localparam logic [1:0] AXIS_LAST = 2'd2;
    localparam int CNT_W = $clog2(vegd_pkg::DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(vegd_pkg::DIV_STEPS - 1);

    logic [4:0]       state_reg, state_next;
    logic [1:0]       axis_reg, axis_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // next state and command
    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = vegd_pkg::OP_NONE;
        cmd.axis       = axis_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = vegd_pkg::OP_LOAD;
                    axis_next  = 2'd0;
                    state_next = ST_ACC_M;
                end
            end
            ST_ACC_M:
            begin
                cmd.op     = vegd_pkg::OP_ACC_M;
                state_next = ST_ACC_W;
            end
            ST_ACC_W:
            begin
                cmd.op     = vegd_pkg::OP_ACC_W;
                state_next = ST_DT_M;
            end
            ST_DT_M:
            begin
                cmd.op     = vegd_pkg::OP_DT_M;
                state_next = ST_DT_W;
            end
            ST_DT_W:
            begin
                cmd.op     = vegd_pkg::OP_DT_W;
                state_next = ST_MEAS;
            end
            ST_MEAS:
            begin
                cmd.op = vegd_pkg::OP_MEAS;
                if (axis_reg == AXIS_LAST)
                begin
                    axis_next  = 2'd0;
                    state_next = ST_SQ_M;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_ACC_M;
                end
            end
            ST_SQ_M:
            begin
                cmd.op     = vegd_pkg::OP_SQ_M;
                state_next = ST_SQ_W;
            end
            ST_SQ_W:
            begin
                cmd.op = vegd_pkg::OP_SQ_W;
                if (axis_reg == AXIS_LAST)
                begin
                    axis_next  = 2'd0;
                    state_next = ST_SIG_M;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_SQ_M;
                end
            end
            ST_SIG_M:
            begin
                cmd.op     = vegd_pkg::OP_SIG_M;
                state_next = ST_SIG_W;
            end
            ST_SIG_W:
            begin
                cmd.op     = vegd_pkg::OP_SIG_W;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.op   = vegd_pkg::OP_CMP;
                cnt_next = '0;
                // exponent of 16 or more: gain is zero, skip straight to output
                if (status.gain_zero)
                    state_next = ST_OUT_M;
                else
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op   = vegd_pkg::OP_DIV;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                    state_next = ST_LOG_M;
            end
            ST_LOG_M:
            begin
                cmd.op     = vegd_pkg::OP_LOG_M;
                state_next = ST_LOG_W;
            end
            ST_LOG_W:
            begin
                cmd.op     = vegd_pkg::OP_LOG_W;
                state_next = ST_INT_M;
            end
            ST_INT_M:
            begin
                cmd.op     = vegd_pkg::OP_INT_M;
                state_next = ST_INT_W;
            end
            ST_INT_W:
            begin
                cmd.op     = vegd_pkg::OP_INT_W;
                state_next = ST_GAIN;
            end
            ST_GAIN:
            begin
                cmd.op     = vegd_pkg::OP_GAIN;
                state_next = ST_OUT_M;
            end
            ST_OUT_M:
            begin
                cmd.op     = vegd_pkg::OP_OUT_M;
                state_next = ST_OUT_W;
            end
            ST_OUT_W:
            begin
                cmd.op = vegd_pkg::OP_OUT_W;
                if (axis_reg == AXIS_LAST)
                begin
                    axis_next  = 2'd0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_OUT_M;
                end
            end
            ST_EMIT:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    cmd.op         = vegd_pkg::OP_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= 2'd0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: design/vegd_dp.sv
// Datapath: config registers, velocity state, shared multiplier, divider, exp gain.
// Depends on vegd_pkg; driven by commands from vegd_ctrl.
module vegd_dp
#(
    parameter int FRAC_BITS = vegd_pkg::FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  vegd_pkg::cmd_t     cmd,
    output vegd_pkg::status_t  status,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic [63:0]        in_data,
    output logic [62:0]        out_data
);

    localparam int ACC_SHIFT = 38 - FRAC_BITS;
    localparam int M2_SHIFT  = 2 * FRAC_BITS - 16;

    // configuration
    logic        mode_reg;
    logic [15:0] sigma_film_reg;
    logic [15:0] sigma_aero_reg;

    // per-item registers
    logic signed [15:0] raw_reg [3];
    logic [15:0]        dt_reg;
    logic signed [31:0] acc_reg;
    logic signed [31:0] vel_reg [3];
    logic [63:0]        sum_reg;
    logic [31:0]        s2_reg;
    logic [63:0]        m2_reg;
    logic [31:0]        rem_reg;
    logic [19:0]        q_reg;
    logic [5:0]         n_reg;
    logic [15:0]        f_reg;
    logic [16:0]        hi_reg;
    logic [16:0]        val_reg;
    logic [15:0]        g_reg;
    logic [20:0]        motor_reg [3];
    logic [62:0]        out_reg;
    logic signed [65:0] prod_reg;

    // combinational helpers
    logic signed [32:0] mul_a, mul_b;
    logic signed [15:0] raw_sel;
    logic signed [31:0] vel_sel;
    logic [31:0]        vel_mag;
    logic [15:0]        sigma_sel;
    logic signed [65:0] acc_rnd, dt_rnd, half_rnd, out_rnd, out_neg;
    logic signed [65:0] vel_dt, vel_meas;
    logic [32:0]        div_t;
    logic [21:0]        y_val;
    logic [16:0]        tab_hi, tab_lo;
    logic [63:0]        gain_t;
    logic [63:0]        gain_v;

    assign sigma_sel = mode_reg ? sigma_aero_reg : sigma_film_reg;

    // axis selection
    always_comb
    begin
        unique case (cmd.axis)
            2'd0:    begin raw_sel = raw_reg[0]; vel_sel = vel_reg[0]; end
            2'd1:    begin raw_sel = raw_reg[1]; vel_sel = vel_reg[1]; end
            default: begin raw_sel = raw_reg[2]; vel_sel = vel_reg[2]; end
        endcase
    end

    assign vel_mag = vel_sel[31] ? 32'(-vel_sel) : 32'(vel_sel);

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            vegd_pkg::OP_ACC_M:
            begin
                mul_a = 33'(raw_sel);
                mul_b = $signed({5'd0, vegd_pkg::ACC_SCALE});
            end
            vegd_pkg::OP_DT_M:
            begin
                mul_a = $signed({17'd0, dt_reg});
                mul_b = 33'(acc_reg);
            end
            vegd_pkg::OP_SQ_M:
            begin
                mul_a = $signed({1'b0, vel_mag});
                mul_b = $signed({1'b0, vel_mag});
            end
            vegd_pkg::OP_SIG_M:
            begin
                mul_a = $signed({17'd0, sigma_sel});
                mul_b = $signed({17'd0, sigma_sel});
            end
            vegd_pkg::OP_LOG_M:
            begin
                mul_a = $signed({13'd0, q_reg});
                mul_b = $signed({16'd0, vegd_pkg::LOG2E});
            end
            vegd_pkg::OP_INT_M:
            begin
                mul_a = $signed({16'd0, 17'(tab_hi - tab_lo)});
                mul_b = $signed({21'd0, f_reg[11:0]});
            end
            vegd_pkg::OP_OUT_M:
            begin
                mul_a = $signed({17'd0, g_reg});
                mul_b = 33'(vel_sel);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // arithmetic on the registered product
    assign acc_rnd  = vegd_pkg::rnd_shr(prod_reg, ACC_SHIFT);
    assign dt_rnd   = vegd_pkg::rnd_shr(prod_reg, 16);
    assign vel_dt   = 66'(vel_sel) + dt_rnd;
    assign half_rnd = vegd_pkg::rnd_shr(66'(acc_reg) - 66'(vel_sel), 1);
    assign vel_meas = 66'(vel_sel) + half_rnd;
    assign out_rnd  = vegd_pkg::rnd_shr(prod_reg, 16);
    assign out_neg  = -out_rnd;

    // gain is zero when |v|^2 / (2 sigma^2) would reach 16 or more
    assign status.gain_zero = (m2_reg[63:29] != 35'd0) || ({m2_reg[28:0], 3'b000} >= s2_reg);

    assign div_t  = {rem_reg, 1'b0};
    assign y_val  = 22'((prod_reg[36:0] + 37'd32768) >> 16);
    assign tab_hi = vegd_pkg::pow2_neg({1'b0, f_reg[15:12]});
    assign tab_lo = vegd_pkg::pow2_neg(5'({1'b0, f_reg[15:12]} + 5'd1));

    // rounding shift of the interpolated value by the integer exponent
    always_comb
    begin
        gain_t = {47'd0, val_reg};
        if (n_reg == 6'd0)
            gain_v = gain_t;
        else if (n_reg > 6'd40)
            gain_v = 64'd0;
        else
            gain_v = (gain_t + (64'd1 << (n_reg - 6'd1))) >> n_reg;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= 1'b0;
            sigma_film_reg <= vegd_pkg::SIGMA_FILM_RST;
            sigma_aero_reg <= vegd_pkg::SIGMA_AERO_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == vegd_pkg::CFG_MODE)
                mode_reg <= cfg_data[0];
            else if (cfg_index == vegd_pkg::CFG_SIGMA_FILM)
                sigma_film_reg <= cfg_data;
            else if (cfg_index == vegd_pkg::CFG_SIGMA_AERO)
                sigma_aero_reg <= cfg_data;
        end
    end

    // velocity state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_reg[0] <= '0;
            vel_reg[1] <= '0;
            vel_reg[2] <= '0;
        end
        else if (cmd.op == vegd_pkg::OP_DT_W)
            vel_reg[cmd.axis] <= vegd_pkg::sat32(vel_dt);
        else if (cmd.op == vegd_pkg::OP_MEAS)
            vel_reg[cmd.axis] <= vegd_pkg::sat32(vel_meas);
    end

    // working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= 66'(mul_a * mul_b);
        unique case (cmd.op)
            vegd_pkg::OP_LOAD:
            begin
                raw_reg[0] <= $signed(in_data[15:0]);
                raw_reg[1] <= $signed(in_data[31:16]);
                raw_reg[2] <= $signed(in_data[47:32]);
                dt_reg     <= in_data[63:48];
                sum_reg    <= '0;
            end
            vegd_pkg::OP_ACC_W:
                acc_reg <= acc_rnd[31:0];
            vegd_pkg::OP_SQ_W:
                sum_reg <= sum_reg + prod_reg[63:0];
            vegd_pkg::OP_SIG_W:
            begin
                s2_reg <= prod_reg[31:0];
                m2_reg <= sum_reg >> M2_SHIFT;
            end
            vegd_pkg::OP_CMP:
            begin
                rem_reg <= {m2_reg[28:0], 3'b000};
                q_reg   <= '0;
                if (status.gain_zero)
                    g_reg <= '0;
            end
            vegd_pkg::OP_DIV:
            begin
                if (div_t >= {1'b0, s2_reg})
                begin
                    rem_reg <= 32'(div_t - {1'b0, s2_reg});
                    q_reg   <= {q_reg[18:0], 1'b1};
                end
                else
                begin
                    rem_reg <= div_t[31:0];
                    q_reg   <= {q_reg[18:0], 1'b0};
                end
            end
            vegd_pkg::OP_LOG_W:
            begin
                n_reg <= y_val[21:16];
                f_reg <= y_val[15:0];
            end
            vegd_pkg::OP_INT_M:
                hi_reg <= tab_hi;
            vegd_pkg::OP_INT_W:
                val_reg <= 17'(hi_reg - 17'((prod_reg[29:0] + 30'd2048) >> 12));
            vegd_pkg::OP_GAIN:
                g_reg <= (gain_v > 64'd65535) ? 16'hFFFF : gain_v[15:0];
            vegd_pkg::OP_OUT_W:
            begin
                if (out_neg > vegd_pkg::OUT_MAX)
                    motor_reg[cmd.axis] <= vegd_pkg::OUT_MAX[20:0];
                else if (out_neg < -vegd_pkg::OUT_MAX)
                    motor_reg[cmd.axis] <= 21'(-vegd_pkg::OUT_MAX);
                else
                    motor_reg[cmd.axis] <= out_neg[20:0];
            end
            vegd_pkg::OP_EMIT:
                out_reg <= {motor_reg[2], motor_reg[1], motor_reg[0]};
            default:
            begin
            end
        endcase
    end

    assign out_data = out_reg;

endmodule

FILE: design/velocity_estimate_gaussian_damping.sv
// Top level of the Gaussian-damped velocity estimator.
// Depends on vegd_pkg, vegd_ctrl and vegd_dp.
//
// Usage:
//   s_axis: one beat per IMU sample, tdata = accel_x, accel_y, accel_z, dt_step.
//   m_axis: one beat per sample, tdata = motor_x, motor_y, motor_z.
//   cfg:    register writes (mode_select, sigma_film, sigma_aero), always ready;
//           write only while no sample is in flight. Indexes beyond 2 are ignored.
// Timing: one sample is worked at a time, in the bit-serial divider for
//   |v|^2 / (2 sigma^2) and in turns of the one shared 33x33 multiplier; the divider
//   and the gain steps are skipped when the gain is zero. s_axis_tready returns together
//   with m_axis_tvalid, so a new sample is taken only once the last one is done.
// Output register: a result waits in its own register, the next sample is accepted
//   and worked meanwhile; if the receiver still stalls when that sample finishes,
//   the block holds it and s_axis_tready stays low.
// Reset: velocity clears to zero, registers take their defaults (film mode,
//   sigma_film 3277, sigma_aero 819), no beat is pending on either side.
module velocity_estimate_gaussian_damping
#(
    parameter int FRAC_BITS = vegd_pkg::FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32], dt_step[63:48]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // motor_x[20:0], motor_y[41:21], motor_z[62:42], zero[63]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    vegd_pkg::cmd_t    cmd;
    vegd_pkg::status_t status;
    logic [62:0]       out_data;

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = {1'b0, out_data};

    vegd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    vegd_dp #(.FRAC_BITS(FRAC_BITS)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .out_data  (out_data)
    );

endmodule
